FILE: rtl/rvdec_pkg.sv
// Shared types, opcode and operation constants, and lookup functions for the instruction decoder.
package rvdec_pkg;

    // Major opcodes, bits 6 to 0 of the instruction word
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    // Format class, chosen by the opcode alone
    typedef enum logic [2:0] {
        FMT_R   = 3'd0,
        FMT_I   = 3'd1,
        FMT_S   = 3'd2,
        FMT_B   = 3'd3,
        FMT_U   = 3'd4,
        FMT_J   = 3'd5,
        FMT_SYS = 3'd6,
        FMT_UNK = 3'd7
    } t_fmt;

    // Dense operation codes
    localparam logic [5:0] OP_UNKNOWN = 6'd0;
    localparam logic [5:0] OP_ADD     = 6'd1;
    localparam logic [5:0] OP_SUB     = 6'd2;
    localparam logic [5:0] OP_SLL     = 6'd3;
    localparam logic [5:0] OP_SLT     = 6'd4;
    localparam logic [5:0] OP_SLTU    = 6'd5;
    localparam logic [5:0] OP_XOR     = 6'd6;
    localparam logic [5:0] OP_SRL     = 6'd7;
    localparam logic [5:0] OP_SRA     = 6'd8;
    localparam logic [5:0] OP_OR      = 6'd9;
    localparam logic [5:0] OP_AND     = 6'd10;
    localparam logic [5:0] OP_ADDI    = 6'd11;
    localparam logic [5:0] OP_SLLI    = 6'd12;
    localparam logic [5:0] OP_SLTI    = 6'd13;
    localparam logic [5:0] OP_SLTIU   = 6'd14;
    localparam logic [5:0] OP_XORI    = 6'd15;
    localparam logic [5:0] OP_SRLI    = 6'd16;
    localparam logic [5:0] OP_SRAI    = 6'd17;
    localparam logic [5:0] OP_ORI     = 6'd18;
    localparam logic [5:0] OP_ANDI    = 6'd19;
    localparam logic [5:0] OP_LB      = 6'd20;
    localparam logic [5:0] OP_LH      = 6'd21;
    localparam logic [5:0] OP_LW      = 6'd22;
    localparam logic [5:0] OP_LBU     = 6'd23;
    localparam logic [5:0] OP_LHU     = 6'd24;
    localparam logic [5:0] OP_SB      = 6'd25;
    localparam logic [5:0] OP_SH      = 6'd26;
    localparam logic [5:0] OP_SW      = 6'd27;
    localparam logic [5:0] OP_BEQ     = 6'd28;
    localparam logic [5:0] OP_BNE     = 6'd29;
    localparam logic [5:0] OP_BLT     = 6'd30;
    localparam logic [5:0] OP_BGE     = 6'd31;
    localparam logic [5:0] OP_BLTU    = 6'd32;
    localparam logic [5:0] OP_BGEU    = 6'd33;
    localparam logic [5:0] OP_JAL     = 6'd34;
    localparam logic [5:0] OP_JALR    = 6'd35;
    localparam logic [5:0] OP_LUI     = 6'd36;
    localparam logic [5:0] OP_AUIPC   = 6'd37;
    localparam logic [5:0] OP_ECALL   = 6'd38;
    localparam logic [5:0] OP_EBREAK  = 6'd39;
    localparam logic [5:0] OP_CSRRW   = 6'd40;
    localparam logic [5:0] OP_CSRRS   = 6'd41;
    localparam logic [5:0] OP_CSRRC   = 6'd42;
    localparam logic [5:0] OP_CSRRWI  = 6'd43;
    localparam logic [5:0] OP_CSRRSI  = 6'd44;
    localparam logic [5:0] OP_CSRRCI  = 6'd45;

    // Stage payloads
    typedef struct packed {
        logic [31:0] word;
        t_fmt        fmt;
    } t_stage1;

    typedef struct packed {
        logic [31:0] word;
        t_fmt        fmt;
        logic [5:0]  op;
        logic [31:0] imm;
    } t_stage2;

    function automatic logic [5:0] f_r_op(input logic [2:0] f3);
        logic [5:0] v;
        unique case (f3)
            3'd0:    v = OP_ADD;
            3'd1:    v = OP_SLL;
            3'd2:    v = OP_SLT;
            3'd3:    v = OP_SLTU;
            3'd4:    v = OP_XOR;
            3'd5:    v = OP_SRL;
            3'd6:    v = OP_OR;
            default: v = OP_AND;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] f_i_op(input logic [2:0] f3);
        logic [5:0] v;
        unique case (f3)
            3'd0:    v = OP_ADDI;
            3'd1:    v = OP_SLLI;
            3'd2:    v = OP_SLTI;
            3'd3:    v = OP_SLTIU;
            3'd4:    v = OP_XORI;
            3'd5:    v = OP_SRLI;
            3'd6:    v = OP_ORI;
            default: v = OP_ANDI;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] f_load_op(input logic [2:0] f3);
        logic [5:0] v;
        unique case (f3)
            3'd0:    v = OP_LB;
            3'd1:    v = OP_LH;
            3'd2:    v = OP_LW;
            3'd4:    v = OP_LBU;
            3'd5:    v = OP_LHU;
            default: v = OP_UNKNOWN;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] f_store_op(input logic [2:0] f3);
        logic [5:0] v;
        unique case (f3)
            3'd0:    v = OP_SB;
            3'd1:    v = OP_SH;
            3'd2:    v = OP_SW;
            default: v = OP_UNKNOWN;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] f_branch_op(input logic [2:0] f3);
        logic [5:0] v;
        unique case (f3)
            3'd0:    v = OP_BEQ;
            3'd1:    v = OP_BNE;
            3'd4:    v = OP_BLT;
            3'd5:    v = OP_BGE;
            3'd6:    v = OP_BLTU;
            3'd7:    v = OP_BGEU;
            default: v = OP_UNKNOWN;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] f_csr_op(input logic [2:0] f3);
        logic [5:0] v;
        unique case (f3)
            3'd1:    v = OP_CSRRW;
            3'd2:    v = OP_CSRRS;
            3'd3:    v = OP_CSRRC;
            3'd5:    v = OP_CSRRWI;
            3'd6:    v = OP_CSRRSI;
            3'd7:    v = OP_CSRRCI;
            default: v = OP_UNKNOWN;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/rvdec_class.sv
// First pipeline stage: capture the instruction word and classify its opcode.
module rvdec_class
    import rvdec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_word,
    input  logic        i_hold,
    output logic        o_stall,
    output logic        o_valid,
    output t_stage1     o_stage
);

    logic    r_valid;
    t_stage1 r_stage;
    logic    n_valid;
    t_stage1 n_stage;
    logic    w_en;

    // The stage takes a new beat when empty or when its beat moves on
    assign w_en    = !r_valid || !i_hold;
    assign o_stall = r_valid && i_hold;

    always_comb begin
        n_valid      = i_valid;
        n_stage.word = i_word;
        unique case (i_word[6:0])
            OPC_OP:     n_stage.fmt = FMT_R;
            OPC_OPIMM,
            OPC_LOAD,
            OPC_JALR:   n_stage.fmt = FMT_I;
            OPC_STORE:  n_stage.fmt = FMT_S;
            OPC_BRANCH: n_stage.fmt = FMT_B;
            OPC_LUI,
            OPC_AUIPC:  n_stage.fmt = FMT_U;
            OPC_JAL:    n_stage.fmt = FMT_J;
            OPC_SYSTEM: n_stage.fmt = FMT_SYS;
            default:    n_stage.fmt = FMT_UNK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: rtl/rvdec_fields.sv
// Second pipeline stage: build the immediate and the dense operation code.
module rvdec_fields
    import rvdec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_stage1     i_stage,
    input  logic        i_hold,
    output logic        o_stall,
    output logic        o_valid,
    output t_stage2     o_stage
);

    logic        r_valid;
    t_stage2     r_stage;
    t_stage2     n_stage;
    logic        w_en;
    logic [31:0] w;
    logic [2:0]  w_f3;
    logic        w_f7_nz;

    assign w_en    = !r_valid || !i_hold;
    assign o_stall = r_valid && i_hold;

    assign w       = i_stage.word;
    assign w_f3    = w[14:12];
    assign w_f7_nz = (w[31:25] != 7'd0);

    always_comb begin
        n_stage.word = w;
        n_stage.fmt  = i_stage.fmt;

        unique case (i_stage.fmt)
            FMT_I:   n_stage.imm = {{20{w[31]}}, w[31:20]};
            FMT_S:   n_stage.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            FMT_B:   n_stage.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_U:   n_stage.imm = {w[31:12], 12'd0};
            FMT_J:   n_stage.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default: n_stage.imm = 32'd0;
        endcase

        unique case (w[6:0])
            OPC_OP: begin
                if (w_f3 == 3'd0 && w_f7_nz) begin
                    n_stage.op = OP_SUB;
                end else if (w_f3 == 3'd5 && w_f7_nz) begin
                    n_stage.op = OP_SRA;
                end else begin
                    n_stage.op = f_r_op(w_f3);
                end
            end
            OPC_OPIMM: begin
                if (w_f3 == 3'd5 && w_f7_nz) begin
                    n_stage.op = OP_SRAI;
                end else begin
                    n_stage.op = f_i_op(w_f3);
                end
            end
            OPC_LOAD:   n_stage.op = f_load_op(w_f3);
            OPC_STORE:  n_stage.op = f_store_op(w_f3);
            OPC_BRANCH: n_stage.op = f_branch_op(w_f3);
            OPC_JAL:    n_stage.op = OP_JAL;
            OPC_JALR:   n_stage.op = OP_JALR;
            OPC_LUI:    n_stage.op = OP_LUI;
            OPC_AUIPC:  n_stage.op = OP_AUIPC;
            OPC_SYSTEM: begin
                if (w == WORD_ECALL) begin
                    n_stage.op = OP_ECALL;
                end else if (w == WORD_EBREAK) begin
                    n_stage.op = OP_EBREAK;
                end else begin
                    n_stage.op = f_csr_op(w_f3);
                end
            end
            default:    n_stage.op = OP_UNKNOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: rtl/rv32i_instruction_decoder.sv
// Top level of the three-stage RV32I instruction decoder.
//
// Decodes one 32-bit RV32I instruction word per beat into its format class,
// register and function fields, sign-extended immediate, CSR number and a
// dense operation code. The block keeps no architectural state. It takes one
// beat every cycle as long as the output side is not stalled, and each
// accepted beat passes in turn through the three register stages: word
// capture with opcode classification, immediate and operation decode, and
// the output register. Each stage holds its own valid bit; a stage refills
// in the same cycle that its beat moves on, so a stall on the output side
// only stops the stages that are full and o_stall rises only when all three
// hold a beat. Both channels use a valid/stall handshake: a beat moves at a
// rising edge where valid is high and stall is low. Reset is synchronous
// and active low and empties the pipeline.
module rv32i_instruction_decoder
    import rvdec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_instruction_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_operation,
    output logic [2:0]         o_format_class,
    output logic [4:0]         o_dest_reg,
    output logic [4:0]         o_src1_reg,
    output logic [4:0]         o_src2_reg,
    output logic [2:0]         o_func3_field,
    output logic [6:0]         o_func7_field,
    output logic signed [31:0] o_immediate,
    output logic [11:0]        o_csr_address
);

    logic    s1_valid;
    t_stage1 s1_stage;
    logic    s1_hold;
    logic    s2_valid;
    t_stage2 s2_stage;
    logic    s2_hold;

    logic    r_valid;
    t_stage2 r_out;
    logic    w_en;

    // Stage one: capture the word and classify the opcode
    rvdec_class u_class (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_instruction_word),
        .i_hold  (s1_hold),
        .o_stall (o_stall),
        .o_valid (s1_valid),
        .o_stage (s1_stage)
    );

    // Stage two: immediate and operation code
    rvdec_fields u_fields (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_stage (s1_stage),
        .i_hold  (s2_hold),
        .o_stall (s1_hold),
        .o_valid (s2_valid),
        .o_stage (s2_stage)
    );

    // Stage three: output register; hold the beat while the sink stalls
    assign w_en    = !r_valid || !i_stall;
    assign s2_hold = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= s2_stage;
        end
    end

    // Fixed fields come straight from the held word
    assign o_valid        = r_valid;
    assign o_operation    = r_out.op;
    assign o_format_class = r_out.fmt;
    assign o_dest_reg     = r_out.word[11:7];
    assign o_src1_reg     = r_out.word[19:15];
    assign o_src2_reg     = r_out.word[24:20];
    assign o_func3_field  = r_out.word[14:12];
    assign o_func7_field  = r_out.word[31:25];
    assign o_immediate    = $signed(r_out.imm);
    assign o_csr_address  = r_out.word[31:20];

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An unknown opcode never yields a known operation
    a_unknown_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_format_class == FMT_UNK) |-> (o_operation == OP_UNKNOWN))
        else $error("known operation for unknown opcode");

    // Classes without an immediate give zero
    a_imm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_format_class == FMT_R || o_format_class == FMT_SYS ||
                     o_format_class == FMT_UNK)) |-> (o_immediate == 32'sd0))
        else $error("nonzero immediate for a class without one");

    // Register-register operations only come from the R class
    a_r_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_operation >= OP_ADD && o_operation <= OP_AND)
            |-> (o_format_class == FMT_R))
        else $error("register operation outside the R class");

    // Full pipeline under an output stall pushes back on the source
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall) |-> (o_valid && i_stall))
        else $error("input stalled while output stage can move");

endmodule
